### sv/ttc_pkg.sv
// Shared constants, types and trit functions for the ternary trit table cipher.
`timescale 1ns / 1ps
`default_nettype none

package ttc_pkg;

    localparam int KEY_DEPTH = 256;
    localparam int KEY_AW    = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;

    localparam int KEY_IDX_W = 8;
    localparam int KEY_BYTE_W = 8;
    localparam int TRITS_W   = 12;
    localparam int VALUE_W   = 16;
    localparam int RESULT_W  = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [9:0]  TRIT_MOD    = 10'd729;
    localparam logic [16:0] MOD_RECIP   = 17'd92057;
    localparam int          RECIP_SHIFT = 26;
    localparam int          QUOT_W      = 7;

    localparam logic [9:0] TRIT_W [6] = '{10'd243, 10'd81, 10'd27, 10'd9, 10'd3, 10'd1};

    localparam logic KIND_KEY_LOAD = 1'b0;
    localparam logic KIND_DATA     = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 1'b1;

    localparam logic [1:0] TRIT_ZERO = 2'd0;
    localparam logic [1:0] TRIT_ONE  = 2'd1;
    localparam logic [1:0] TRIT_TWO  = 2'd2;

    typedef struct packed {
        logic                  load;
        logic                  lookup;
        logic [KEY_IDX_W-1:0]  index;
        logic [TRITS_W-1:0]    trits;
    } key_req_t;

    // Splits a value below 729 into six trits, the heaviest in the top two bits.
    function automatic logic [TRITS_W-1:0] pack_trits(input logic [9:0] v);
        logic [9:0]         rem;
        logic [TRITS_W-1:0] p;
        rem = v;
        p   = '0;
        for (int i = 0; i < 6; i++)
        begin
            if (rem >= (TRIT_W[i] << 1))
            begin
                p[2*(5-i) +: 2] = TRIT_TWO;
                rem = rem - (TRIT_W[i] << 1);
            end
            else if (rem >= TRIT_W[i])
            begin
                p[2*(5-i) +: 2] = TRIT_ONE;
                rem = rem - TRIT_W[i];
            end
            else
            begin
                p[2*(5-i) +: 2] = TRIT_ZERO;
            end
        end
        return p;
    endfunction

    // Self-inverse table: a key trit of zero swaps data trits zero and two.
    function automatic logic [1:0] combine_trit(input logic [1:0] d, input logic [1:0] k);
        logic [1:0] r;
        r = d;
        if (k == TRIT_ZERO)
        begin
            if (d == TRIT_ZERO)
                r = TRIT_TWO;
            else if (d == TRIT_TWO)
                r = TRIT_ZERO;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/ttc_key_store.sv
// Key trit memory with the key position counter and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ttc_key_store (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ttc_pkg::key_req_t            req,
    input  wire logic [ttc_pkg::KEY_IDX_W-1:0] key_length,
    output logic      [ttc_pkg::TRITS_W-1:0]  key_trits
);
    import ttc_pkg::*;

    logic [TRITS_W-1:0]   mem [KEY_DEPTH];
    logic [TRITS_W-1:0]   rd_data_reg;
    logic                 rd_in_range_reg;
    logic [KEY_IDX_W-1:0] pos_reg;
    logic [KEY_IDX_W-1:0] pos_next;
    logic [KEY_IDX_W:0]   pos_inc;
    logic                 wr_in_range;
    logic                 rd_in_range;

    assign wr_in_range = ({1'b0, req.index} < (KEY_IDX_W+1)'(KEY_DEPTH));
    assign rd_in_range = ({1'b0, pos_reg} < (KEY_IDX_W+1)'(KEY_DEPTH));
    assign pos_inc     = {1'b0, pos_reg} + (KEY_IDX_W+1)'(1);

    always_comb
    begin
        pos_next = pos_reg;
        if (req.load)
            pos_next = '0;
        else if (req.lookup)
            pos_next = (pos_inc >= {1'b0, key_length}) ? '0 : pos_inc[KEY_IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (req.load && wr_in_range)
            mem[req.index[KEY_AW-1:0]] <= req.trits;
        if (req.lookup)
            rd_data_reg <= mem[pos_reg[KEY_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            rd_in_range_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (req.lookup)
                rd_in_range_reg <= rd_in_range;
        end
    end

    assign key_trits = rd_in_range_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

### sv/ternary_trit_table_cipher.sv
// Top level of the ternary trit table cipher: stream ports, registers and trit pipeline.
//
//  Channel  Direction  Transfer condition      Contents
//  s_*      in         s_tvalid && s_tready    key load or data item
//  m_*      out        m_tvalid && m_tready    one result per data item
//  cfg_*    in         cfg_we                  direction, key_length
//
// One item is accepted per cycle unless a stalled output has filled every stage; a
// data item's result passes the key memory read followed by four pipeline stages
// (reciprocal multiply, remainder, trit split, table and recombination).
// Reset clears the pipeline, key position and direction and sets key_length to 1;
// key memory is undefined until loaded. A stalled output fills the empty stages first.
`timescale 1ns / 1ps
`default_nettype none

module ternary_trit_table_cipher (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [31:0]                    s_tdata,  // key_index, key_byte, data_value
    input  wire logic                           s_tuser,  // kind
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [15:0]                    m_tdata,  // result_value, zero fill
    input  wire logic                           cfg_we,
    input  wire logic [ttc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ttc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ttc_pkg::*;

    logic                  direction_reg;
    logic [KEY_IDX_W-1:0]  key_length_reg;

    logic [KEY_IDX_W-1:0]  in_key_index;
    logic [KEY_BYTE_W-1:0] in_key_byte;
    logic [VALUE_W-1:0]    in_data_value;
    logic                  accept;
    logic                  accept_data;

    key_req_t              key_req;
    logic [TRITS_W-1:0]    key_trits;

    logic                  v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic                  take1, take2, take3, take4, take_out;

    logic [VALUE_W-1:0]    val1_reg;
    logic [VALUE_W-1:0]    val2_reg;
    logic [QUOT_W-1:0]     quot2_reg;
    logic [TRITS_W-1:0]    key2_reg, key3_reg, key4_reg;
    logic [9:0]            rem3_reg;
    logic [TRITS_W-1:0]    dtrits4_reg;
    logic [RESULT_W-1:0]   out_data_reg;

    logic [VALUE_W+16:0]   product;
    logic [16:0]           rem_raw;
    logic [16:0]           rem_fix;
    logic [RESULT_W-1:0]   sum;
    logic [RESULT_W-1:0]   result;

    assign in_key_index  = s_tdata[7:0];
    assign in_key_byte   = s_tdata[15:8];
    assign in_data_value = s_tdata[31:16];

    assign take_out = !out_valid_reg || m_tready;
    assign take4    = !v4_reg || take_out;
    assign take3    = !v3_reg || take4;
    assign take2    = !v2_reg || take3;
    assign take1    = !v1_reg || take2;

    assign s_tready    = take1;
    assign accept      = s_tvalid && take1;
    assign accept_data = accept && (s_tuser == KIND_DATA);

    always_comb
    begin
        key_req.load   = accept && (s_tuser == KIND_KEY_LOAD);
        key_req.lookup = accept_data;
        key_req.index  = in_key_index;
        key_req.trits  = pack_trits({2'b00, in_key_byte});
    end

    ttc_key_store u_key_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (key_req),
        .key_length (key_length_reg),
        .key_trits  (key_trits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg  <= 1'b0;
            key_length_reg <= KEY_IDX_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DIRECTION:  direction_reg  <= cfg_data[0];
                REG_KEY_LENGTH: key_length_reg <= cfg_data[KEY_IDX_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take1)
                v1_reg <= accept_data;
            if (take2)
                v2_reg <= v1_reg;
            if (take3)
                v3_reg <= v2_reg;
            if (take4)
                v4_reg <= v3_reg;
            if (take_out)
                out_valid_reg <= v4_reg;
        end
    end

    assign product = val1_reg * MOD_RECIP;
    assign rem_raw = {1'b0, val2_reg} - (17'(quot2_reg) * 17'(TRIT_MOD));
    assign rem_fix = (rem_raw >= 17'(TRIT_MOD)) ? (rem_raw - 17'(TRIT_MOD)) : rem_raw;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < 6; i++)
        begin
            sum = sum + TRIT_W[i] * RESULT_W'(combine_trit(dtrits4_reg[2*(5-i) +: 2],
                                                           key4_reg[2*(5-i) +: 2]));
        end
        result = direction_reg ? {2'b00, sum[7:0]} : sum;
    end

    always_ff @(posedge clk)
    begin
        if (take1)
            val1_reg <= in_data_value;
        if (take2)
        begin
            val2_reg  <= val1_reg;
            quot2_reg <= product[RECIP_SHIFT +: QUOT_W];
            key2_reg  <= key_trits;
        end
        if (take3)
        begin
            rem3_reg <= rem_fix[9:0];
            key3_reg <= key2_reg;
        end
        if (take4)
        begin
            dtrits4_reg <= pack_trits(rem3_reg);
            key4_reg    <= key3_reg;
        end
        if (take_out)
            out_data_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b000000, out_data_reg};

endmodule

`default_nettype wire
